// ===== rtl/nis_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nis_pkg;

	localparam int RADICAND_W    = 32;
	localparam int ROOT_W        = 16;
	localparam int REM_W         = 17;
	localparam int ROOT_BITS_DEF = 16;

endpackage

`default_nettype wire

// ===== rtl/nonrestoring_integer_sqrt_core.sv =====
// Non-restoring integer square root, one recurrence step per pipeline stage.
// Pipeline: one registered stage for each of the ROOT_BITS digit steps from an accepted
// start, plus the correction stage that registers done, root and remainder.
// Throughput: one transaction per cycle; busy stays low because no stage ever stalls.
// Reset clears only the stage valid bits and the done strobe; data stages are not reset.
// The receiver cannot stall; every result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module nonrestoring_integer_sqrt_core #(
	parameter int ROOT_BITS = nis_pkg::ROOT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [nis_pkg::RADICAND_W-1:0] radicand,
	output logic                               done,
	output logic [nis_pkg::ROOT_W-1:0]          root,
	output logic [nis_pkg::REM_W-1:0]           remainder
);

	import nis_pkg::*;

	localparam int RW    = ROOT_BITS + 2;
	localparam int RAD_W = 2 * ROOT_BITS;

	logic [RAD_W-1:0] rad_ext;

	logic                 vld_s  [1:ROOT_BITS];
	logic [RW-1:0]        rem_s  [1:ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [1:ROOT_BITS];
	logic [RAD_W-1:0]     rad_s  [1:ROOT_BITS];

	logic [RW-1:0]     rem_fix;
	logic [ROOT_W-1:0] root_ext;
	logic [REM_W-1:0]  rem_ext;

	logic              done_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;

	// Radicand bits above bit 31 read as zero when the recurrence is wider.
	for (genvar b = 0; b < RAD_W; b++) begin : g_rad
		if (b < RADICAND_W) begin : g_in
			assign rad_ext[b] = radicand[b];
		end else begin : g_zero
			assign rad_ext[b] = 1'b0;
		end
	end

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
		logic                 vld_in;
		logic [RW-1:0]        rem_in;
		logic [ROOT_BITS-1:0] root_in;
		logic [RAD_W-1:0]     rad_in;
		logic [RW-1:0]        shifted;
		logic [RW-1:0]        rem_nx;

		if (k == 0) begin : g_first
			assign vld_in  = start;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad_ext;
		end else begin : g_next
			assign vld_in  = vld_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign rad_in  = rad_s[k];
		end

		assign shifted = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};

		// A negative partial remainder adds (root<<2)|3, otherwise (root<<2)|1 is subtracted.
		always_comb begin
			if (rem_in[RW-1]) begin
				rem_nx = shifted + {root_in, 2'b11};
			end else begin
				rem_nx = shifted - {root_in, 2'b01};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_nx;
			root_s[k+1] <= {root_in[ROOT_BITS-2:0], ~rem_nx[RW-1]};
			rad_s[k+1]  <= {rad_in[RAD_W-3:0], 2'b00};
		end
	end

	always_comb begin
		if (rem_s[ROOT_BITS][RW-1]) begin
			rem_fix = rem_s[ROOT_BITS] + {1'b0, root_s[ROOT_BITS], 1'b1};
		end else begin
			rem_fix = rem_s[ROOT_BITS];
		end
	end

	for (genvar b = 0; b < ROOT_W; b++) begin : g_root_out
		if (b < ROOT_BITS) begin : g_bit
			assign root_ext[b] = root_s[ROOT_BITS][b];
		end else begin : g_zero
			assign root_ext[b] = 1'b0;
		end
	end

	for (genvar b = 0; b < REM_W; b++) begin : g_rem_out
		if (b < RW) begin : g_bit
			assign rem_ext[b] = rem_fix[b];
		end else begin : g_zero
			assign rem_ext[b] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[ROOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		root_q <= root_ext;
		rem_q  <= rem_ext;
	end

	assign busy      = 1'b0;
	assign done      = done_q;
	assign root      = root_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/nis_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nis_checker #(
	parameter int ROOT_BITS = nis_pkg::ROOT_BITS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic [nis_pkg::RADICAND_W-1:0] radicand,
	input wire logic                           done,
	input wire logic [nis_pkg::ROOT_W-1:0]     root,
	input wire logic [nis_pkg::REM_W-1:0]      remainder
);

	import nis_pkg::*;

	localparam int LAT = ROOT_BITS + 1;

	// The pipeline never stalls, so it never refuses a transaction.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a stall-free pipeline");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted transaction");

	a_zero_radicand: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && radicand == '0) |-> ##LAT (root == '0 && remainder == '0))
		else $error("zero radicand gave a nonzero result");

	// Without truncation the remainder can never exceed twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ROOT_BITS <= ROOT_W && done) |->
			({1'b0, remainder} <= {1'b0, root, 1'b0}))
		else $error("remainder exceeds twice the root");

endmodule

bind nonrestoring_integer_sqrt_core nis_checker #(.ROOT_BITS(ROOT_BITS)) u_nis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.radicand  (radicand),
	.done      (done),
	.root      (root),
	.remainder (remainder)
);

`default_nettype wire

// ===== tb/sqrt_result_checker.sv =====
`timescale 1ns / 1ps

module sqrt_result_checker #(
	parameter int ROOT_BITS = nis_pkg::ROOT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic [nis_pkg::RADICAND_W-1:0] radicand,
	input  wire logic                          done,
	input  wire logic [nis_pkg::ROOT_W-1:0]     root,
	input  wire logic [nis_pkg::REM_W-1:0]      remainder,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 checked,
	output int                                 exact_squares
);

	import nis_pkg::*;

	typedef struct packed {
		logic [RADICAND_W-1:0] rad;
		logic [ROOT_W-1:0]     root;
		logic [REM_W-1:0]      rem;
	} sqrt_expect_t;

	sqrt_expect_t sqrt_expected_q[$];

	// Digit recurrence with a 64-bit two's complement partial remainder.
	function automatic sqrt_expect_t predict_sqrt(input logic [RADICAND_W-1:0] rad);
		sqrt_expect_t res;
		logic [63:0]  q;
		logic [63:0]  r;
		logic [63:0]  pair;
		logic [63:0]  shifted;
		int           sh;
		q = '0;
		r = '0;
		for (int i = ROOT_BITS - 1; i >= 0; i--) begin
			sh = 2 * i;
			pair = (sh < 64) ? ((64'(rad) >> sh) & 64'd3) : 64'd0;
			shifted = (r << 2) | pair;
			if (!r[63]) begin
				r = shifted - ((q << 2) | 64'd1);
			end else begin
				r = shifted + ((q << 2) | 64'd3);
			end
			q = (q << 1) | {63'd0, ~r[63]};
		end
		if (r[63]) begin
			r = r + ((q << 1) | 64'd1);
		end
		res.rad  = rad;
		res.root = q[ROOT_W-1:0];
		res.rem  = r[REM_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sqrt_expect_t exp_item;
		if (!arst_n) begin
			sqrt_expected_q.delete();
			mismatches    = 0;
			pending       = 0;
			checked       = 0;
			exact_squares = 0;
		end else begin
			if (done) begin
				if (sqrt_expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result root=%0d remainder=%0d",
							$realtime, root, remainder);
					end
				end else begin
					exp_item = sqrt_expected_q.pop_front();
					checked++;
					if (root !== exp_item.root || remainder !== exp_item.rem) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: radicand 0x%08h expected %0d rem %0d, got %0d rem %0d",
								$realtime, exp_item.rad, exp_item.root, exp_item.rem,
								root, remainder);
						end
					end else if (exp_item.rem == '0) begin
						exact_squares++;
					end
				end
			end
			if (start && !busy) begin
				sqrt_expected_q.push_back(predict_sqrt(radicand));
			end
			pending = sqrt_expected_q.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import nis_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int CALM_TAIL    = 300;
	localparam int PIPE_DEPTH   = ROOT_BITS_DEF + 1;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [RADICAND_W-1:0] radicand;
	logic                  done;
	logic [ROOT_W-1:0]     root;
	logic [REM_W-1:0]      remainder;

	logic                  issue_taken;
	int                    mismatches;
	int                    pending;
	int                    checked;
	int                    exact_squares;
	int                    cycles;

	nonrestoring_integer_sqrt_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.radicand  (radicand),
		.done      (done),
		.root      (root),
		.remainder (remainder)
	);

	sqrt_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.radicand      (radicand),
		.done          (done),
		.root          (root),
		.remainder     (remainder),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked),
		.exact_squares (exact_squares)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Records at each rising edge whether the transaction on the inputs was taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_taken <= 1'b0;
		end else begin
			issue_taken <= start && !busy;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("nonrestoring_integer_sqrt_core regression: fail");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue_radicand(input logic [RADICAND_W-1:0] value);
		start    <= 1'b1;
		radicand <= value;
		do begin
			@(negedge clk);
		end while (!issue_taken);
	endtask

	initial begin
		logic [RADICAND_W-1:0] directed[$];
		logic [RADICAND_W-1:0] k;
		logic [RADICAND_W-1:0] value;
		int                    gap;
		int                    kind;

		arst_n   = 1'b0;
		start    = 1'b0;
		radicand = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Field extremes, squares on both sides, the largest remainder, bit patterns.
		directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
			32'h0000_0004, 32'h0000_0008, 32'h0000_0010, 32'h0000_FFFF,
			32'h0001_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFE_0000,
			32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
			32'h0000_0063, 32'h0000_0064, 32'h0098_9680};
		foreach (directed[i]) begin
			issue_radicand(directed[i]);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			k = $urandom_range(0, 65535);
			if (kind < 40) begin
				value = $urandom();
			end else if (kind < 60) begin
				value = k * k;
			end else if (kind < 70) begin
				value = (k == 0) ? '0 : k * k - 1;
			end else if (kind < 80) begin
				// One below the next square gives the largest remainder for this root.
				value = k * k + 2 * k;
			end else if (kind < 90) begin
				value = $urandom_range(0, 1023);
			end else begin
				value = $urandom() >> $urandom_range(1, 31);
			end
			issue_radicand(value);
			if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 19);
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		start <= 1'b0;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_DEPTH + 8) @(negedge clk);

		$display("checked %0d square roots, %0d of them exact squares", checked,
			exact_squares);
		$display("mismatches: %0d, results still outstanding: %0d", mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("nonrestoring_integer_sqrt_core regression: pass");
		end else begin
			$display("nonrestoring_integer_sqrt_core regression: fail");
		end
		$finish;
	end

endmodule
